/* rtl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants of the sorted merge with duplicate removal.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int SMD_DEPTH    = 256;
  localparam int SMD_KEY_BITS = 64;

  localparam int KEY_W   = 64;
  localparam int GROUP_W = 8;
  localparam int ITEM_W  = 32;
  localparam int ID_W    = GROUP_W + ITEM_W;
  localparam int DEL_W   = 10;
  localparam int ACT_W   = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 160;

  localparam logic [DEL_W-1:0] DEL_MAX = 10'd512;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_LEFT  = 2'd0,
    ACT_LOAD_RIGHT = 2'd1,
    ACT_POP        = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  // Control from the merge decision to one list.
  typedef struct packed {
    logic push;
    logic clear;
    logic advance;
  } list_ctl_t;

  // Status of one list: a head entry exists, and a second one behind it.
  typedef struct packed {
    logic have;
    logic more;
  } list_stat_t;

endpackage

/* rtl/sorted_merge_dedup_top.sv */
// ----------------------------------------------------------------------------
// sorted_merge_dedup_top
// Merges two sorted key lists into one, removing equal-key duplicates.
// ----------------------------------------------------------------------------
// Usage. Each request on the in_ channel carries an action in in_tuser:
// load left, load right, pop or clear. Loads append an entry (key, group,
// item number) to the left or right list; loads beyond DEPTH entries since
// the last clear are dropped. A pop compares the two list heads as unsigned
// keys and sends the smaller entry on the out_ channel; on equal keys one
// entry is sent and the other is reported as a deleted duplicate, the choice
// being set by the keep_newer bit written through the cfg_ channel. Loads,
// clears and pops that find both lists used up produce no output request.
// An accepted request passes the input and output registers to out_tvalid.
// One request is taken every cycle while the receiver does not stall, set by
// the combinational head compare and the one read port of each list store.
// When the receiver stalls, the output register holds its request and the
// input register fills, after which in_tready drops. Reset empties both lists,
// zeroes the deleted count and clears keep_newer; the stores need no clearing.
// ----------------------------------------------------------------------------
module sorted_merge_dedup_top #(
  parameter int DEPTH    = smd_pkg::SMD_DEPTH,
  parameter int KEY_BITS = smd_pkg::SMD_KEY_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key [63:0], group [71:64], item_index [103:72]
  input  logic [smd_pkg::IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [smd_pkg::ACT_W-1:0]      in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_key [63:0], out_group [71:64], out_item [103:72], del_group [111:104],
  // del_item [143:112], deleted_total [153:144], zero padding [159:154]
  output logic [smd_pkg::OUT_DATA_W-1:0] out_tdata,
  // dup_found [0]
  output logic                           out_tuser,
  output logic                           out_tlast,
  // Configuration: keep_newer.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  import smd_pkg::*;

  // Input register.
  logic                s1_valid_r;
  action_t             s1_act_r;
  logic [KEY_BITS-1:0] s1_key_r;
  logic [ID_W-1:0]     s1_id_r;

  logic keep_newer_r;
  logic [DEL_W-1:0] del_cnt_r, del_cnt_nxt;

  // Output register.
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [ID_W-1:0]   out_id_r;
  logic              dup_r;
  logic [ID_W-1:0]   del_id_r;
  logic [DEL_W-1:0]  del_total_r;
  logic              last_r;

  logic go;
  logic is_pop;
  logic emit;

  list_ctl_t           l_ctl, r_ctl;
  list_stat_t          l_stat, r_stat;
  logic [KEY_BITS-1:0] l_key, r_key;
  logic [ID_W-1:0]     l_id, r_id;

  logic [KEY_BITS-1:0] sel_key;
  logic [ID_W-1:0]     sel_id;
  logic [ID_W-1:0]     sel_del_id;
  logic                sel_dup;
  logic                adv_l, adv_r;
  logic                last_nxt;

  // The item in the input register is worked on when the output register is
  // free or being emptied in this cycle.
  assign go        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_act_r <= action_t'(in_tuser);
      s1_key_r <= in_tdata[KEY_BITS-1:0];
      s1_id_r  <= {in_tdata[71:64], in_tdata[103:72]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_newer_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keep_newer_r <= cfg_data;
    end
  end

  // Head compare and selection for a pop.
  always_comb begin
    sel_key    = l_key;
    sel_id     = l_id;
    sel_del_id = '0;
    sel_dup    = 1'b0;
    adv_l      = 1'b0;
    adv_r      = 1'b0;
    if (l_stat.have && r_stat.have) begin
      if (l_key < r_key) begin
        adv_l = 1'b1;
      end else if (l_key > r_key) begin
        sel_key = r_key;
        sel_id  = r_id;
        adv_r   = 1'b1;
      end else begin
        sel_dup = 1'b1;
        adv_l   = 1'b1;
        adv_r   = 1'b1;
        if (keep_newer_r) begin
          sel_id     = r_id;
          sel_del_id = l_id;
        end else begin
          sel_del_id = r_id;
        end
      end
    end else if (l_stat.have) begin
      adv_l = 1'b1;
    end else begin
      sel_key = r_key;
      sel_id  = r_id;
      adv_r   = r_stat.have;
    end
  end

  assign is_pop = go && (s1_act_r == ACT_POP);
  assign emit   = is_pop && (l_stat.have || r_stat.have);

  assign l_ctl.push    = go && (s1_act_r == ACT_LOAD_LEFT);
  assign l_ctl.clear   = go && (s1_act_r == ACT_CLEAR);
  assign l_ctl.advance = is_pop && adv_l;
  assign r_ctl.push    = go && (s1_act_r == ACT_LOAD_RIGHT);
  assign r_ctl.clear   = l_ctl.clear;
  assign r_ctl.advance = is_pop && adv_r;

  // Both lists are used up once this pop has taken its heads.
  assign last_nxt = !(adv_l ? l_stat.more : l_stat.have) &&
                    !(adv_r ? r_stat.more : r_stat.have);

  always_comb begin
    del_cnt_nxt = del_cnt_r;
    if (l_ctl.clear) begin
      del_cnt_nxt = '0;
    end else if (emit && sel_dup && (del_cnt_r < DEL_MAX)) begin
      del_cnt_nxt = del_cnt_r + DEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      del_cnt_r <= '0;
    end else begin
      del_cnt_r <= del_cnt_nxt;
    end
  end

  smd_list #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (l_ctl),
    .push_key (s1_key_r),
    .push_id  (s1_id_r),
    .stat     (l_stat),
    .head_key (l_key),
    .head_id  (l_id)
  );

  smd_list #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (r_ctl),
    .push_key (s1_key_r),
    .push_id  (s1_id_r),
    .stat     (r_stat),
    .head_key (r_key),
    .head_id  (r_id)
  );

  // Output register: held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_key_r   <= KEY_W'(sel_key);
      out_id_r    <= sel_id;
      dup_r       <= sel_dup;
      del_id_r    <= sel_del_id;
      del_total_r <= del_cnt_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = dup_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0,
                       del_total_r,
                       del_id_r[ITEM_W-1:0],
                       del_id_r[ID_W-1:ITEM_W],
                       out_id_r[ITEM_W-1:0],
                       out_id_r[ID_W-1:ITEM_W],
                       out_key_r};

endmodule

/* rtl/smd_ram.sv */
// ----------------------------------------------------------------------------
// smd_ram
// Single write port, single registered read port memory with write bypass.
// ----------------------------------------------------------------------------
module smd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 104
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the address being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/smd_list.sv */
// ----------------------------------------------------------------------------
// smd_list
// One sorted input list: entry store, fill count and read position, with the
// head entry presented from the registered memory read.
// ----------------------------------------------------------------------------
module smd_list #(
  parameter int DEPTH    = smd_pkg::SMD_DEPTH,
  parameter int KEY_BITS = smd_pkg::SMD_KEY_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  smd_pkg::list_ctl_t       ctl,
  input  logic [KEY_BITS-1:0]      push_key,
  input  logic [smd_pkg::ID_W-1:0] push_id,
  output smd_pkg::list_stat_t      stat,
  output logic [KEY_BITS-1:0]      head_key,
  output logic [smd_pkg::ID_W-1:0] head_id
);

  import smd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + ID_W;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          full;
  logic          wr_en;
  logic [EW-1:0] rd_entry;

  assign full  = (count_r == CW'(DEPTH));
  assign wr_en = ctl.push && !full;

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (ctl.clear) begin
      count_nxt = '0;
      pos_nxt   = '0;
    end else begin
      if (wr_en) begin
        count_nxt = count_r + CW'(1);
      end
      if (ctl.advance) begin
        pos_nxt = pos_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // The memory is read at the position that will be current next cycle, so
  // its registered output is always the present head.
  smd_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata ({push_key, push_id}),
    .raddr (pos_nxt[AW-1:0]),
    .rdata (rd_entry)
  );

  assign stat.have = (pos_r < count_r);
  assign stat.more = stat.have && ((pos_r + CW'(1)) < count_r);
  assign head_key  = rd_entry[EW-1:ID_W];
  assign head_id   = rd_entry[ID_W-1:0];

endmodule

/* tb/smd_merge_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smd_merge_checker
// Watches the request, result and configuration channels of the sorted merge,
// keeps its own copy of both lists and predicts every merged result in order.
// ----------------------------------------------------------------------------
module smd_merge_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [smd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [smd_pkg::ACT_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [smd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             requests_seen,
  output int                             results_seen,
  output int                             dups_seen,
  output int                             loads_dropped,
  output int                             top_deleted
);

  import smd_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - SMD_KEY_BITS);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GROUP_W-1:0] group;
    logic [ITEM_W-1:0]  item;
    logic               dup;
    logic [GROUP_W-1:0] del_group;
    logic [ITEM_W-1:0]  del_item;
    logic [DEL_W-1:0]   deleted_total;
    logic               last;
  } merge_result_t;

  logic [KEY_W-1:0] left_keys  [SMD_DEPTH];
  logic [ID_W-1:0]  left_ids   [SMD_DEPTH];
  logic [KEY_W-1:0] right_keys [SMD_DEPTH];
  logic [ID_W-1:0]  right_ids  [SMD_DEPTH];
  int               left_count, right_count, left_pos, right_pos;
  logic [DEL_W-1:0] deleted_count;
  logic             keep_newer;
  merge_result_t    awaited_results[$];

  // Applies one accepted request to the list copies and queues its result.
  function automatic void predict_merge(action_t act, logic [KEY_W-1:0] key,
                                        logic [GROUP_W-1:0] grp, logic [ITEM_W-1:0] item);
    merge_result_t res;
    logic          lhave, rhave;
    res = '0;
    case (act)
      ACT_LOAD_LEFT: begin
        if (left_count < SMD_DEPTH) begin
          left_keys[left_count] = key & KEY_MASK;
          left_ids[left_count]  = {grp, item};
          left_count++;
        end else begin
          loads_dropped++;
        end
      end
      ACT_LOAD_RIGHT: begin
        if (right_count < SMD_DEPTH) begin
          right_keys[right_count] = key & KEY_MASK;
          right_ids[right_count]  = {grp, item};
          right_count++;
        end else begin
          loads_dropped++;
        end
      end
      ACT_CLEAR: begin
        left_count    = 0;
        right_count   = 0;
        left_pos      = 0;
        right_pos     = 0;
        deleted_count = '0;
      end
      default: begin
        lhave = left_pos < left_count;
        rhave = right_pos < right_count;
        if (lhave || rhave) begin
          if (lhave && rhave && left_keys[left_pos] == right_keys[right_pos]) begin
            res.key = left_keys[left_pos];
            res.dup = 1'b1;
            if (keep_newer) begin
              {res.group, res.item}         = right_ids[right_pos];
              {res.del_group, res.del_item} = left_ids[left_pos];
            end else begin
              {res.group, res.item}         = left_ids[left_pos];
              {res.del_group, res.del_item} = right_ids[right_pos];
            end
            left_pos++;
            right_pos++;
            if (deleted_count < DEL_MAX) deleted_count++;
          end else if (lhave && (!rhave || left_keys[left_pos] < right_keys[right_pos])) begin
            res.key               = left_keys[left_pos];
            {res.group, res.item} = left_ids[left_pos];
            left_pos++;
          end else begin
            res.key               = right_keys[right_pos];
            {res.group, res.item} = right_ids[right_pos];
            right_pos++;
          end
          res.deleted_total = deleted_count;
          res.last          = (left_pos >= left_count) && (right_pos >= right_count);
          awaited_results.push_back(res);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    merge_result_t want;
    if (!rst_n) begin
      left_count    = 0;
      right_count   = 0;
      left_pos      = 0;
      right_pos     = 0;
      deleted_count = '0;
      keep_newer    = 1'b0;
      awaited_results.delete();
      fail_count    = 0;
      requests_seen = 0;
      results_seen  = 0;
      dups_seen     = 0;
      loads_dropped = 0;
      top_deleted   = 0;
    end else begin
      // Results first: a result can only belong to an earlier request.
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %0h",
                   $time, out_tdata[63:0]);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_key",       want.key,                out_tdata[63:0]);
          check_field("out_group",     64'(want.group),         64'(out_tdata[71:64]));
          check_field("out_item",      64'(want.item),          64'(out_tdata[103:72]));
          check_field("del_group",     64'(want.del_group),     64'(out_tdata[111:104]));
          check_field("del_item",      64'(want.del_item),      64'(out_tdata[143:112]));
          check_field("deleted_total", 64'(want.deleted_total), 64'(out_tdata[153:144]));
          check_field("padding",       '0,                      64'(out_tdata[159:154]));
          check_field("dup_found",     64'(want.dup),           64'(out_tuser));
          check_field("last",          64'(want.last),          64'(out_tlast));
          results_seen++;
          if (want.dup) dups_seen++;
          if (int'(want.deleted_total) > top_deleted) top_deleted = int'(want.deleted_total);
        end
      end
      if (cfg_valid && cfg_ready) keep_newer = cfg_data;
      if (in_tvalid && in_tready) begin
        requests_seen++;
        predict_merge(action_t'(in_tuser), in_tdata[63:0], in_tdata[71:64], in_tdata[103:72]);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, pop and clear requests into the sorted merge, switches the
// duplicate policy between phases and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module testbench;
  import smd_pkg::*;

  // Total number of requests after which no new phase is started.
  localparam int REQUEST_TARGET = 1750;
  // Hard stop; a clean run needs a small fraction of this.
  localparam int CYCLE_LIMIT    = 1_000_000;
  // This comfortably covers any pop still held in the input register that finds
  // both lists empty and yields no result.
  localparam int SETTLE_CYCLES  = 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data   = 1'b0;

  int fail_count, pending, requests_seen, results_seen, dups_seen;
  int loads_dropped, top_deleted;

  // Idling behaviour per phase: 0 never idles, 1 short gaps, 2 adds long ones.
  int in_gap_mode    = 0;
  int out_stall_mode = 0;
  int stall_left     = 0;
  int cycles         = 0;
  int sent           = 0;
  int cfg_writes     = 0;

  sorted_merge_dedup_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  smd_merge_checker merge_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .dups_seen     (dups_seen),
    .loads_dropped (loads_dropped),
    .top_deleted   (top_deleted)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_merge_dedup_top verification failed");
      $finish;
    end
  end

  // Mostly no gap, some short gaps and, in the harshest mode, a few long ones.
  function automatic int pick_gap(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == 0 || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (mode == 1) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Most list lengths are small so that phases turn over quickly; a few are
  // long enough to build deep runs of equal keys.
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(0, 12);
    if (roll < 97) return $urandom_range(13, 48);
    return $urandom_range(49, 120);
  endfunction

  // Ascending keys with small steps, so that both lists often share keys and
  // equal keys also follow each other within one list. The rare huge step may
  // wrap and leave a list out of order, which the block must also cope with.
  function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] prev);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return prev + KEY_W'($urandom_range(0, 2));
    if (roll < 95) return prev + KEY_W'($urandom_range(3, 1000));
    return prev + {$urandom, $urandom};
  endfunction

  // Result side: the receiver stalls at random for the lengths that pick_gap
  // gives, with whole phases of no stalling when the mode is zero.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(out_stall_mode);
    out_tready <= (stall_left == 0);
  end

  // Presents one request and holds it until it is taken, then perhaps idles.
  // With no gap the valid stays high, so the next request follows directly.
  task automatic send_req(action_t act, logic [KEY_W-1:0] key,
                          logic [GROUP_W-1:0] grp, logic [ITEM_W-1:0] item);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {item, grp, key};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has been received, then waits out
  // SETTLE_CYCLES for pops that produce nothing. The first edge is always
  // taken so that the checker has counted the last request.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called once the block is idle.
  task automatic set_keep_newer(logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int               nl, nr, npops, roll;
    logic [KEY_W-1:0] lkey, rkey, base;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part --------------------------------------------------
    in_gap_mode    = 1;
    out_stall_mode = 1;
    // A pop straight after reset finds both lists empty and yields nothing.
    send_req(ACT_POP, '1, '1, '1);
    // Left holds zero, a middle key and the largest key; right duplicates the
    // two extremes and adds a key with only the top bit set.
    send_req(ACT_LOAD_LEFT,  '0, '0, '0);
    send_req(ACT_LOAD_LEFT,  64'h0123_4567_89AB_CDEF, 8'h5A, 32'h1234_5678);
    send_req(ACT_LOAD_LEFT,  '1, 8'hFF, 32'hFFFF_FFFF);
    send_req(ACT_LOAD_RIGHT, '0, 8'hA5, 32'h8765_4321);
    send_req(ACT_LOAD_RIGHT, 64'h8000_0000_0000_0000, 8'h01, 32'h0000_0001);
    send_req(ACT_LOAD_RIGHT, '1, 8'h7F, 32'h7FFF_FFFF);
    // Duplicate at zero, left wins, right wins, duplicate at the top (last),
    // then a pop with both lists used up.
    repeat (5) send_req(ACT_POP, '0, '0, '0);
    // A load after the lists ran dry is appended behind what was consumed.
    send_req(ACT_LOAD_LEFT, 64'd5, 8'h3C, 32'h0000_ABCD);
    send_req(ACT_POP, '0, '0, '0);
    // A clear drops everything, so the following pop yields nothing.
    send_req(ACT_LOAD_RIGHT, 64'd9, 8'h11, 32'h2222_3333);
    send_req(ACT_CLEAR, '1, '1, '1);
    send_req(ACT_POP, '0, '0, '0);
    settle();
    // With keep_newer set the right entry survives an equal key.
    set_keep_newer(1'b1);
    send_req(ACT_LOAD_LEFT,  64'd7, 8'h01, 32'h0000_0001);
    send_req(ACT_LOAD_RIGHT, 64'd7, 8'h02, 32'h0000_0002);
    send_req(ACT_LOAD_RIGHT, 64'd3, 8'h03, 32'h0000_0003);
    repeat (3) send_req(ACT_POP, '0, '0, '0);
    settle();

    // ---- Full stores ----------------------------------------------------
    // Both lists filled to capacity with identical keys, a few loads beyond
    // capacity that must be dropped, then every entry popped: all pops but the
    // last are duplicates; the deleted total climbs to its largest reachable value.
    set_keep_newer(1'($urandom_range(0, 1)));
    in_gap_mode    = 0;
    out_stall_mode = 2;
    send_req(ACT_CLEAR, '0, '0, '0);
    base = {$urandom, $urandom} >> 1;
    for (int i = 0; i < SMD_DEPTH + 3; i++) begin
      send_req(ACT_LOAD_LEFT,  base + KEY_W'(i), GROUP_W'($urandom), $urandom);
      send_req(ACT_LOAD_RIGHT, base + KEY_W'(i), GROUP_W'($urandom), $urandom);
    end
    repeat (SMD_DEPTH + 1) send_req(ACT_POP, '0, '0, '0);
    settle();

    // ---- Random phases --------------------------------------------------
    while (sent < REQUEST_TARGET) begin
      in_gap_mode    = $urandom_range(0, 2);
      out_stall_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        settle();
        set_keep_newer(1'($urandom_range(0, 1)));
      end
      // Now and then the clear is skipped, so entries pile up across phases
      // and the stores eventually fill and drop loads.
      if ($urandom_range(0, 9) != 0) begin
        send_req(ACT_CLEAR, {$urandom, $urandom}, GROUP_W'($urandom), $urandom);
      end
      nl    = pick_size();
      nr    = pick_size();
      npops = nl + nr + 1;
      roll  = $urandom_range(0, 99);
      if (roll < 80) base = {$urandom, $urandom};
      else if (roll < 90) base = '0;
      else base = 64'hFFFF_FFFF_FFFF_FFF0;
      lkey = base;
      rkey = base;
      // Loads interleaved with early pops; a little noise of arbitrary
      // requests, clears included.
      while (nl > 0 || nr > 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_req(action_t'($urandom_range(0, 3)), {$urandom, $urandom},
                   GROUP_W'($urandom), $urandom);
        end else if (roll < 24) begin
          send_req(ACT_POP, {$urandom, $urandom}, GROUP_W'($urandom), $urandom);
        end else if (nl > 0 && (nr == 0 || $urandom_range(0, 1) == 1)) begin
          lkey = next_key(lkey);
          send_req(ACT_LOAD_LEFT, lkey, GROUP_W'($urandom), $urandom);
          nl--;
        end else begin
          rkey = next_key(rkey);
          send_req(ACT_LOAD_RIGHT, rkey, GROUP_W'($urandom), $urandom);
          nr--;
        end
      end
      // Drain the merge, usually with a spare pop that finds nothing left.
      repeat (npops) send_req(ACT_POP, {$urandom, $urandom}, GROUP_W'($urandom), $urandom);
    end

    settle();
    $display("Run covered %0d requests and %0d keep_newer writes; %0d merged results checked.",
             requests_seen, cfg_writes, results_seen);
    $display("Duplicates removed: %0d, highest deleted total: %0d, loads dropped: %0d.",
             dups_seen, top_deleted, loads_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_merge_dedup_top verification clean");
    end else begin
      $display("sorted_merge_dedup_top verification failed");
    end
    $finish;
  end

endmodule
